>>> rtl/core/akd_pkg.sv
// Shared types, widths, thresholds and window tables for the analog keypad decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package akd_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int TIME_BITS   = 32;
    localparam int LOCK_BITS   = 16;
    localparam int CODE_BITS   = 3;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = LOCK_BITS;
    localparam int NUM_WIN     = 4;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [TIME_BITS-1:0]   t_time;
    typedef logic [LOCK_BITS-1:0]   t_lock;
    typedef logic [CODE_BITS-1:0]   t_code;

    // Button codes
    localparam t_code CODE_NONE   = 3'd0;
    localparam t_code CODE_RIGHT  = 3'd1;
    localparam t_code CODE_UP     = 3'd2;
    localparam t_code CODE_DOWN   = 3'd3;
    localparam t_code CODE_LEFT   = 3'd4;
    localparam t_code CODE_SELECT = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LOCKOUT    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOARD_MODE = 1'd1;

    localparam t_lock LOCKOUT_RESET = 16'd50;
    localparam logic  BOARD_RESET   = 1'b1;

    // Decision thresholds
    localparam t_sample STABLE_TOL = SAMPLE_BITS'(10);
    localparam t_sample MOVE_MIN   = SAMPLE_BITS'(30);
    localparam t_sample RIGHT_MAX  = SAMPLE_BITS'(20);

    // Exclusive window bounds for up, down, left, select; row 0 second ladder, row 1 first
    localparam t_sample WIN_LO [2][NUM_WIN] = '{
        '{SAMPLE_BITS'(90),  SAMPLE_BITS'(245), SAMPLE_BITS'(400), SAMPLE_BITS'(630)},
        '{SAMPLE_BITS'(200), SAMPLE_BITS'(395), SAMPLE_BITS'(615), SAMPLE_BITS'(815)}
    };
    localparam t_sample WIN_HI [2][NUM_WIN] = '{
        '{SAMPLE_BITS'(110), SAMPLE_BITS'(265), SAMPLE_BITS'(420), SAMPLE_BITS'(650)},
        '{SAMPLE_BITS'(230), SAMPLE_BITS'(420), SAMPLE_BITS'(635), SAMPLE_BITS'(835)}
    };

    // Outcome of one item from the decision stage
    typedef struct packed {
        logic  accept;
        t_code code;
    } t_decide;

endpackage

`default_nettype wire

>>> rtl/core/akd_classify.sv
// Maps a level to a button code through the window table of the selected ladder.
// Depends on akd_pkg.
`default_nettype none

module akd_classify (
    input  wire akd_pkg::t_sample i_level,
    input  wire                   i_board_mode,
    output akd_pkg::t_code        o_code
);
    import akd_pkg::*;

    always_comb begin
        o_code = CODE_NONE;
        // scan high to low so the lowest matching window wins
        for (int i = NUM_WIN - 1; i >= 0; i--) begin
            if (i_level > WIN_LO[i_board_mode][i] && i_level < WIN_HI[i_board_mode][i]) begin
                o_code = CODE_UP + CODE_BITS'(i);
            end
        end
        if (i_level < RIGHT_MAX) begin
            o_code = CODE_RIGHT;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/akd_judge.sv
// Averages the readings, gates on stability, lockout and level change, and holds
// the last accepted level and time. Depends on akd_pkg and akd_classify.
`default_nettype none

module akd_judge (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_fire,
    input  wire akd_pkg::t_sample i_ref_sample,
    input  wire akd_pkg::t_sample i_avg_sample_a,
    input  wire akd_pkg::t_sample i_avg_sample_b,
    input  wire akd_pkg::t_sample i_avg_sample_c,
    input  wire akd_pkg::t_sample i_avg_sample_d,
    input  wire akd_pkg::t_time   i_now_ms,
    input  wire akd_pkg::t_lock   i_lockout_ms,
    input  wire                   i_board_mode,
    output akd_pkg::t_decide      o_decide
);
    import akd_pkg::*;

    t_sample r_held_level, n_held_level;
    t_time   r_last_ms,    n_last_ms;

    logic [SAMPLE_BITS+1:0] sum;
    t_sample avg;
    t_sample avg_diff;
    t_sample held_diff;
    t_time   elapsed;
    logic    stable;
    logic    late;
    logic    moved;
    logic    accept;
    t_code   cls_code;

    akd_classify u_classify (
        .i_level      (i_ref_sample),
        .i_board_mode (i_board_mode),
        .o_code       (cls_code)
    );

    always_comb begin
        sum = {2'b00, i_avg_sample_a} + {2'b00, i_avg_sample_b}
            + {2'b00, i_avg_sample_c} + {2'b00, i_avg_sample_d};
        avg = sum[SAMPLE_BITS+1:2];
        avg_diff  = (avg >= i_ref_sample) ? (avg - i_ref_sample) : (i_ref_sample - avg);
        held_diff = (i_ref_sample >= r_held_level) ? (i_ref_sample - r_held_level)
                                                   : (r_held_level - i_ref_sample);
        // modular difference handles timer wrap
        elapsed = i_now_ms - r_last_ms;
        stable  = (avg_diff <= STABLE_TOL);
        late    = (elapsed > TIME_BITS'(i_lockout_ms));
        moved   = (held_diff >= MOVE_MIN);
        accept  = i_fire && stable && late && moved;

        n_held_level = accept ? i_ref_sample : r_held_level;
        n_last_ms    = accept ? i_now_ms : r_last_ms;

        o_decide.accept = accept;
        o_decide.code   = accept ? cls_code : CODE_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_level <= '0;
            r_last_ms    <= '0;
        end else begin
            r_held_level <= n_held_level;
            r_last_ms    <= n_last_ms;
        end
    end

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_held_level) && $stable(r_last_ms))
        else $error("held state changed without an accepted change");

    a_take_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_held_level == $past(i_ref_sample) && r_last_ms == $past(i_now_ms))
        else $error("accepted level or time not stored");

    a_code_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_decide.code != CODE_NONE |-> accept && stable && moved)
        else $error("button code without accepted change");

endmodule

`default_nettype wire

>>> rtl/core/analog_keypad_decoder.sv
// Analog keypad decoder: an accepted input item goes into the input register, then is
// decided and stored in the result register. Throughput one item per cycle while the
// result is not stalled; the only loop is the held level and time. Input stalls only
// while both stages are full and the result is stalled. Synchronous active-low reset:
// empties both stages, clears held level and time, sets lockout to 50 ms and board
// mode to the first ladder.
`default_nettype none

module analog_keypad_decoder (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration write port
    input  wire                                   i_cfg_we,
    input  wire [akd_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire [akd_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    // input item channel
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire akd_pkg::t_sample                 i_ref_sample,
    input  wire akd_pkg::t_sample                 i_avg_sample_a,
    input  wire akd_pkg::t_sample                 i_avg_sample_b,
    input  wire akd_pkg::t_sample                 i_avg_sample_c,
    input  wire akd_pkg::t_sample                 i_avg_sample_d,
    input  wire akd_pkg::t_time                   i_now_ms,
    // result item channel
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output akd_pkg::t_code                        o_button_code
);
    import akd_pkg::*;

    // configuration registers
    t_lock r_lockout_ms;
    logic  r_board_mode;

    // input register: one captured item
    logic    r_in_valid;
    t_sample r_ref, r_sa, r_sb, r_sc, r_sd;
    t_time   r_now;

    // result register
    logic    r_out_valid;
    t_code   r_code;

    logic    advance;
    logic    fire;
    t_decide decide;

    // move the held item forward whenever the result slot is free or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    // stall only while a captured item cannot move on
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout_ms <= LOCKOUT_RESET;
            r_board_mode <= BOARD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LOCKOUT:    r_lockout_ms <= i_cfg_data;
                REG_BOARD_MODE: r_board_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input stage: load a new item whenever the stage is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_ref <= i_ref_sample;
            r_sa  <= i_avg_sample_a;
            r_sb  <= i_avg_sample_b;
            r_sc  <= i_avg_sample_c;
            r_sd  <= i_avg_sample_d;
            r_now <= i_now_ms;
        end
    end

    akd_judge u_judge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_ref_sample   (r_ref),
        .i_avg_sample_a (r_sa),
        .i_avg_sample_b (r_sb),
        .i_avg_sample_c (r_sc),
        .i_avg_sample_d (r_sd),
        .i_now_ms       (r_now),
        .i_lockout_ms   (r_lockout_ms),
        .i_board_mode   (r_board_mode),
        .o_decide       (decide)
    );

    // result stage: every item yields exactly one code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_code <= decide.code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_button_code = r_code;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with room downstream");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("item moved forward but no result shown");

    a_code_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_button_code <= CODE_SELECT)
        else $error("button code out of range");

    a_accept_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        decide.accept |-> fire)
        else $error("level change accepted without an item moving forward");

endmodule

`default_nettype wire

>>> tb/analog_keypad_decoder_test.sv
// Self-checking testbench for analog_keypad_decoder: a scoreboard predicts each button code
// from the accepted item and tracked state; tasks drive items and register writes, and a
// receiver process drives stalls. Depends on akd_pkg and the analog_keypad_decoder RTL.
`timescale 1ns / 1ps

package akd_tb_pkg;
    import akd_pkg::*;

    localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
    localparam int STEADY_TOL  = 10;
    localparam int MIN_MOVE    = 30;
    localparam int RIGHT_LIMIT = 20;

    typedef struct packed {
        t_sample level;
        t_sample samp_a;
        t_sample samp_b;
        t_sample samp_c;
        t_sample samp_d;
        t_time   stamp;
    } t_key_item;

    // Exclusive window bounds for up, down, left, select on each ladder
    function automatic t_sample ladder_bound(input logic ladder, input int slot,
                                             input logic upper);
        int lo;
        int hi;
        if (ladder) begin
            case (slot)
                0: begin lo = 200; hi = 230; end
                1: begin lo = 395; hi = 420; end
                2: begin lo = 615; hi = 635; end
                default: begin lo = 815; hi = 835; end
            endcase
        end else begin
            case (slot)
                0: begin lo = 90;  hi = 110; end
                1: begin lo = 245; hi = 265; end
                2: begin lo = 400; hi = 420; end
                default: begin lo = 630; hi = 650; end
            endcase
        end
        return upper ? t_sample'(hi) : t_sample'(lo);
    endfunction

    class button_scoreboard;
        t_sample     level_held;
        t_time       accept_stamp;
        t_lock       lock_ms;
        logic        ladder;
        t_code       expected_codes[$];
        int unsigned mismatches;

        function new();
            level_held   = '0;
            accept_stamp = '0;
            lock_ms      = LOCKOUT_RESET;
            ladder       = BOARD_RESET;
            mismatches   = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_LOCKOUT)
                lock_ms = data;
            else if (idx == REG_BOARD_MODE)
                ladder = data[0];
        endfunction

        function t_code classify_level(input t_sample level);
            if (level < RIGHT_LIMIT)
                return CODE_RIGHT;
            for (int s = 0; s < NUM_WIN; s++) begin
                if (level > ladder_bound(ladder, s, 1'b0) && level < ladder_bound(ladder, s, 1'b1))
                    return t_code'(CODE_UP + s);
            end
            return CODE_NONE;
        endfunction

        // Decide one item and, if it is accepted, advance the held level and accept time
        function t_code press_code(input t_key_item it);
            logic [SAMPLE_BITS+1:0] total;
            t_sample mean;
            t_sample spread;
            t_sample move;
            t_time   elapsed;
            total  = it.samp_a + it.samp_b + it.samp_c + it.samp_d;
            mean   = total[SAMPLE_BITS+1:2];
            spread = (mean >= it.level) ? mean - it.level : it.level - mean;
            if (spread > STEADY_TOL)
                return CODE_NONE;
            elapsed = it.stamp - accept_stamp;
            move    = (it.level >= level_held) ? it.level - level_held : level_held - it.level;
            if (elapsed <= t_time'(lock_ms) || move < MIN_MOVE)
                return CODE_NONE;
            level_held   = it.level;
            accept_stamp = it.stamp;
            return classify_level(it.level);
        endfunction

        function void note_item(input t_key_item it);
            expected_codes.push_back(press_code(it));
        endfunction

        task report_mismatch(input string what);
            $display("%0t MISMATCH: %s", $time, what);
            mismatches++;
        endtask

        task check_code(input t_code got);
            t_code want;
            if (expected_codes.size() == 0) begin
                report_mismatch($sformatf("button code %0d with nothing expected", got));
            end else begin
                want = expected_codes.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("button code %0d, expected %0d", got, want));
            end
        endtask

        function int pending();
            return expected_codes.size();
        endfunction
    endclass

endpackage

module analog_keypad_decoder_test;
    import akd_pkg::*;
    import akd_tb_pkg::*;

    localparam int LATENCY     = 2;
    localparam int LONG_HOLD   = 64;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     i_in_valid;
    wire                      o_in_stall;
    t_sample                  i_ref_sample;
    t_sample                  i_avg_sample_a;
    t_sample                  i_avg_sample_b;
    t_sample                  i_avg_sample_c;
    t_sample                  i_avg_sample_d;
    t_time                    i_now_ms;
    wire                      o_out_valid;
    logic                     i_out_stall;
    wire  [CODE_BITS-1:0]     o_button_code;

    button_scoreboard sb = new();

    // Stimulus knobs shared between the sender, the receiver and the generators
    bit      tx_idle_on = 1'b1;
    bit      rx_idle_on = 1'b1;
    bit      hold_req   = 1'b0;
    t_time   cur_ms     = '0;

    analog_keypad_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_ref_sample   (i_ref_sample),
        .i_avg_sample_a (i_avg_sample_a),
        .i_avg_sample_b (i_avg_sample_b),
        .i_avg_sample_c (i_avg_sample_c),
        .i_avg_sample_d (i_avg_sample_d),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_button_code  (o_button_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: check every item that leaves the block against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_code(o_button_code);
    end

    // Receiver: random stall bursts, or one long hold-off when requested so the
    // pipeline fills up and pushes back on the sender
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_key_item mk_item(input t_sample level, input int a, input int b,
                                          input int c, input int d, input t_time stamp);
        t_key_item it;
        it.level  = level;
        it.samp_a = t_sample'(a);
        it.samp_b = t_sample'(b);
        it.samp_c = t_sample'(c);
        it.samp_d = t_sample'(d);
        it.stamp  = stamp;
        return it;
    endfunction

    function automatic t_sample clamp_sample(input int v);
        if (v < 0)
            return '0;
        if (v > SAMPLE_MAX)
            return t_sample'(SAMPLE_MAX);
        return t_sample'(v);
    endfunction

    // Four readings that jitter around level+offset but floor-average exactly to it
    function automatic t_key_item steady_item(input t_sample level, input int offset,
                                              input t_time stamp);
        int mean;
        int lim;
        int j;
        int k;
        int c;
        int rem;
        mean = clamp_sample(int'(level) + offset);
        lim  = (mean < SAMPLE_MAX - mean) ? mean : SAMPLE_MAX - mean;
        if (lim > 40)
            lim = 40;
        j   = $urandom_range(0, lim);
        k   = $urandom_range(0, lim);
        rem = $urandom_range(0, 3);
        c   = mean + k;
        if (c + rem <= SAMPLE_MAX)
            c = c + rem;
        return mk_item(level, mean + j, mean - j, c, mean - k, stamp);
    endfunction

    // Levels inside a window of the active ladder, in the right range, on its edges, or random
    function automatic t_sample pick_level(input logic ladder);
        int      slot;
        t_sample lo;
        t_sample hi;
        t_sample level;
        slot = $urandom_range(0, NUM_WIN - 1);
        lo   = ladder_bound(ladder, slot, 1'b0);
        hi   = ladder_bound(ladder, slot, 1'b1);
        case ($urandom_range(0, 5))
            0: level = t_sample'($urandom_range(0, RIGHT_LIMIT - 1));
            1, 2: level = t_sample'($urandom_range(lo + 1, hi - 1));
            3: begin
                case ($urandom_range(0, 4))
                    0: level = lo;
                    1: level = hi;
                    2: level = lo + 1;
                    3: level = hi - 1;
                    default: level = t_sample'(RIGHT_LIMIT);
                endcase
            end
            default: level = t_sample'($urandom_range(0, SAMPLE_MAX));
        endcase
        return level;
    endfunction

    // Time of the next item: usually just past the lockout, sometimes on or inside it
    function automatic t_time next_stamp(input t_time now, input t_lock lock);
        case ($urandom_range(0, 19))
            0, 1: return now + lock;
            2, 3: return now + lock + 1;
            4, 5: return now + $urandom_range(0, lock);
            6: return t_time'($urandom);
            default: return now + lock + 1 + $urandom_range(0, 200);
        endcase
    endfunction

    function automatic t_key_item random_item();
        int pick;
        int off;
        t_sample level;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            // well-formed press: stable readings, usually after the lockout
            level = pick_level(sb.ladder);
            off   = int'($urandom_range(0, 2 * STEADY_TOL)) - STEADY_TOL;
            return steady_item(level, off, next_stamp(cur_ms, sb.lock_ms));
        end
        if (pick < 75) begin
            // drift around the held level, straddling the minimum move
            level = clamp_sample(int'(sb.level_held) + int'($urandom_range(0, 70)) - 35);
            return steady_item(level, 0, next_stamp(cur_ms, sb.lock_ms));
        end
        if (pick < 85) begin
            // unsettled readings just past the tolerance
            level = pick_level(sb.ladder);
            off   = STEADY_TOL + 1 + int'($urandom_range(0, 30));
            if ($urandom_range(0, 1) == 0)
                off = -off;
            return steady_item(level, off, next_stamp(cur_ms, sb.lock_ms));
        end
        // pure noise on every field
        return mk_item(t_sample'($urandom), $urandom_range(0, SAMPLE_MAX),
                       $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                       $urandom_range(0, SAMPLE_MAX),
                       ($urandom_range(0, 3) == 0) ? t_time'($urandom)
                                                   : cur_ms + $urandom_range(0, 2 * sb.lock_ms + 2));
    endfunction

    // Offer one item, with an optional idle burst first, and hold it until taken
    task automatic send_item(input t_key_item it);
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_ref_sample   <= it.level;
        i_avg_sample_a <= it.samp_a;
        i_avg_sample_b <= it.samp_b;
        i_avg_sample_c <= it.samp_c;
        i_avg_sample_d <= it.samp_d;
        i_now_ms       <= it.stamp;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_item(it);
        cur_ms = it.stamp;
    endtask

    // Drop valid and wait until every predicted code has come out
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    initial begin
        t_lock lock_val;
        t_lock mode_word;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_ref_sample   = '0;
        i_avg_sample_a = '0;
        i_avg_sample_b = '0;
        i_avg_sample_c = '0;
        i_avg_sample_d = '0;
        i_now_ms       = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings (lockout 50, first ladder)
        send_item(mk_item(0, 0, 0, 0, 0, 0));                 // zero everything, inside lockout
        send_item(mk_item(1023, 1023, 1023, 1023, 1023, 51)); // full scale, outside every window
        send_item(mk_item(500, 511, 511, 511, 511, 200));     // average one past tolerance
        send_item(mk_item(500, 510, 510, 510, 510, 101));     // elapsed equals lockout
        send_item(mk_item(500, 490, 490, 490, 490, 102));     // lowest stable average, accepted
        send_item(mk_item(529, 529, 529, 529, 529, 1000));    // move of 29 is too small
        send_item(mk_item(470, 470, 470, 470, 470, 1000));    // move of exactly 30
        send_item(mk_item(19, 19, 19, 19, 19, 1100));         // right
        send_item(mk_item(215, 215, 215, 215, 215, 1200));    // up
        send_item(mk_item(408, 408, 408, 408, 408, 1300));    // down
        send_item(mk_item(625, 625, 625, 625, 625, 1400));    // left
        send_item(mk_item(825, 825, 825, 825, 825, 1500));    // select
        send_item(mk_item(20, 20, 20, 20, 20, 1600));         // just above the right window
        send_item(mk_item(230, 230, 230, 230, 230, 1700));    // upper edge of up
        send_item(mk_item(200, 200, 200, 200, 200, 1800));    // lower edge of up
        // wrap of the millisecond counter
        send_item(mk_item(600, 600, 600, 600, 600, 32'hFFFF_FFF0));
        send_item(mk_item(700, 700, 700, 700, 700, 32'h0000_0022));
        send_item(mk_item(700, 700, 700, 700, 700, 32'h0000_0023));
        send_item(mk_item(511, 1023, 0, 1023, 1, 32'h0000_0100)); // extremes averaged, floor
        quiesce();

        // Shortest lockout on the second ladder
        write_reg(REG_LOCKOUT, '0);
        write_reg(REG_BOARD_MODE, '0);
        send_item(mk_item(100, 100, 100, 100, 100, 32'h0000_0100)); // no time has passed
        send_item(mk_item(100, 100, 100, 100, 100, 32'h0000_0101)); // up
        send_item(mk_item(255, 255, 255, 255, 255, 32'h0000_0102)); // down
        send_item(mk_item(410, 410, 410, 410, 410, 32'h0000_0103)); // left
        send_item(mk_item(640, 640, 640, 640, 640, 32'h0000_0104)); // select
        send_item(mk_item(10, 10, 10, 10, 10, 32'h0000_0105));      // right
        send_item(mk_item(90, 90, 90, 90, 90, 32'h0000_0106));      // lower edge of up
        quiesce();

        cur_ms = t_time'($urandom);
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin lock_val = t_lock'($urandom_range(1, 300)); mode_word = 1; end
                1: begin lock_val = '1; mode_word = 0; end
                2: begin lock_val = '0; mode_word = 1; end
                3: begin lock_val = t_lock'($urandom); mode_word = 0; end
                4: begin lock_val = LOCKOUT_RESET; mode_word = 1; end
                5: begin lock_val = t_lock'($urandom_range(1, 30)); mode_word = 0; end
                6: begin lock_val = '0; mode_word = 0; end
                default: begin lock_val = t_lock'($urandom_range(20, 120)); mode_word = 1; end
            endcase
            // only bit 0 selects the ladder; fill the rest with junk
            mode_word = {(LOCK_BITS-1)'($urandom), mode_word[0]};
            write_reg(REG_LOCKOUT, lock_val);
            write_reg(REG_BOARD_MODE, mode_word);
            if (ph == PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == PHASE_ITEMS / 2)
                    quiesce();
                send_item(random_item());
            end
            quiesce();
        end

        repeat (LATENCY + 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
